FILE: sv/tsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsg_pkg;

   // one triangle as it arrives on the request side
   typedef struct packed {
      logic [7:0]  ax;
      logic [5:0]  ay;
      logic [7:0]  bx;
      logic [5:0]  by_row;
      logic [7:0]  cx;
      logic [5:0]  cy;
      logic [15:0] fill_color;
   } req_type;

   // one horizontal span on the response side
   typedef struct packed {
      logic [5:0]  span_row;
      logic [7:0]  span_left;
      logic [7:0]  span_right;
      logic [15:0] span_color;
      logic        last_span;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture and sort the vertices
      logic setup;      // start the edge slope divisions, reset edge trackers
      logic div_step;   // one quotient bit in each divider
      logic emit_flat;  // emit the single span of a flat triangle
      logic emit_span;  // emit the span of the current row and step down
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic flat;       // all three vertices on one row
      logic off_screen; // top row already outside the row limit
      logic row_last;   // current row is the final one emitted
   } ctrl_status_type;

   localparam int unsigned DivSteps = 8;

endpackage

`default_nettype wire

FILE: sv/tsg_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per step, 8-bit dividend by 6-bit divisor
module tsg_divider
   import tsg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       start,
   input  wire logic       step,
   input  wire logic [7:0] dividend,
   input  wire logic [5:0] divisor,
   output logic [7:0]      quotient,
   output logic [5:0]      remainder
);

   logic [7:0] dq_ff, dq_in;
   logic [5:0] rem_ff, rem_in;
   logic [5:0] dvs_ff, dvs_in;
   logic [6:0] trial;
   logic [6:0] diff;
   logic       qbit;

   // partial remainder with next dividend bit shifted in
   always_comb begin
      trial = {rem_ff, dq_ff[7]};
      qbit  = (trial >= {1'b0, dvs_ff});
      diff  = trial - {1'b0, dvs_ff};
      dq_in  = dq_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         dq_in  = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (step) begin
         dq_in  = {dq_ff[6:0], qbit};
         rem_in = qbit ? diff[5:0] : trial[5:0];
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: sv/tsg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tsg_datapath
   import tsg_pkg::*;
#(
   parameter int unsigned ROWS = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_item,
   input  wire ctrl_cmd_type cmd,
   output ctrl_status_type status,
   output logic           rsp_strobe,
   output rsp_type        rsp_item
);

   localparam logic [5:0] LastRow = 6'(ROWS - 1);

   // sorted vertices, top first
   logic [7:0]  vx_ff [3];
   logic [5:0]  vy_ff [3];
   logic [7:0]  vx_in [3];
   logic [5:0]  vy_in [3];
   logic [15:0] color_ff, color_in;

   // edge trackers: quotient and remainder of accumulator / edge height
   logic [5:0] cur_row_ff, cur_row_in;
   logic [7:0] long_q_ff, long_q_in, short_q_ff, short_q_in;
   logic [5:0] long_r_ff, long_r_in, short_r_ff, short_r_in;

   logic    rsp_strobe_ff;
   rsp_type rsp_ff, rsp_in;

   // slope per row: |dx| = a * dy + b
   logic [7:0] abs02, abs01, abs12;
   logic       neg02, neg01, neg12;
   logic [5:0] dy02, dy01, dy12;
   logic [7:0] a02, a01, a12;
   logic [5:0] b02, b01, b12;

   logic       lower;
   logic [7:0] s_a, s_x, long_col, short_col;
   logic [5:0] s_b, s_d;
   logic       s_neg;
   logic [6:0] long_sum, short_sum;
   logic       long_ge, short_ge;
   logic [5:0] next_row;
   logic [7:0] flat_lo, flat_hi;

   // sort by row with three compare-exchange steps
   always_comb begin
      logic [7:0] x [3];
      logic [5:0] y [3];
      logic [7:0] tx;
      logic [5:0] ty;
      tx = '0;
      ty = '0;
      x[0] = req_item.ax; y[0] = req_item.ay;
      x[1] = req_item.bx; y[1] = req_item.by_row;
      x[2] = req_item.cx; y[2] = req_item.cy;
      if (y[0] > y[1]) begin
         tx = x[0]; x[0] = x[1]; x[1] = tx;
         ty = y[0]; y[0] = y[1]; y[1] = ty;
      end
      if (y[1] > y[2]) begin
         tx = x[1]; x[1] = x[2]; x[2] = tx;
         ty = y[1]; y[1] = y[2]; y[2] = ty;
      end
      if (y[0] > y[1]) begin
         tx = x[0]; x[0] = x[1]; x[1] = tx;
         ty = y[0]; y[0] = y[1]; y[1] = ty;
      end
      if (cmd.load) begin
         vx_in    = x;
         vy_in    = y;
         color_in = req_item.fill_color;
      end else begin
         vx_in    = vx_ff;
         vy_in    = vy_ff;
         color_in = color_ff;
      end
   end

   // edge deltas as magnitude and direction
   always_comb begin
      neg02 = vx_ff[2] < vx_ff[0];
      neg01 = vx_ff[1] < vx_ff[0];
      neg12 = vx_ff[2] < vx_ff[1];
      abs02 = neg02 ? vx_ff[0] - vx_ff[2] : vx_ff[2] - vx_ff[0];
      abs01 = neg01 ? vx_ff[0] - vx_ff[1] : vx_ff[1] - vx_ff[0];
      abs12 = neg12 ? vx_ff[1] - vx_ff[2] : vx_ff[2] - vx_ff[1];
      dy02  = vy_ff[2] - vy_ff[0];
      dy01  = vy_ff[1] - vy_ff[0];
      dy12  = vy_ff[2] - vy_ff[1];
   end

   tsg_divider u_div02 (
      .clock(clock), .start(cmd.setup), .step(cmd.div_step),
      .dividend(abs02), .divisor(dy02), .quotient(a02), .remainder(b02)
   );

   tsg_divider u_div01 (
      .clock(clock), .start(cmd.setup), .step(cmd.div_step),
      .dividend(abs01), .divisor(dy01), .quotient(a01), .remainder(b01)
   );

   tsg_divider u_div12 (
      .clock(clock), .start(cmd.setup), .step(cmd.div_step),
      .dividend(abs12), .divisor(dy12), .quotient(a12), .remainder(b12)
   );

   // pick the short edge of the current half
   always_comb begin
      lower = (cur_row_ff >= vy_ff[1]) && (vy_ff[1] != vy_ff[2]);
      s_a   = lower ? a12 : a01;
      s_b   = lower ? b12 : b01;
      s_d   = lower ? dy12 : dy01;
      s_x   = lower ? vx_ff[1] : vx_ff[0];
      s_neg = lower ? neg12 : neg01;
   end

   // span end columns of the current row
   assign long_col  = neg02 ? vx_ff[0] - long_q_ff : vx_ff[0] + long_q_ff;
   assign short_col = s_neg ? s_x - short_q_ff : s_x + short_q_ff;

   // flat triangle extent
   always_comb begin
      flat_lo = vx_ff[0];
      flat_hi = vx_ff[0];
      if (vx_ff[1] < flat_lo) flat_lo = vx_ff[1];
      if (vx_ff[1] > flat_hi) flat_hi = vx_ff[1];
      if (vx_ff[2] < flat_lo) flat_lo = vx_ff[2];
      if (vx_ff[2] > flat_hi) flat_hi = vx_ff[2];
   end

   // tracker stepping: add slope, carry remainder overflow into quotient
   always_comb begin
      long_sum  = {1'b0, long_r_ff} + {1'b0, b02};
      long_ge   = long_sum >= {1'b0, dy02};
      short_sum = {1'b0, short_r_ff} + {1'b0, s_b};
      short_ge  = short_sum >= {1'b0, s_d};
      next_row  = cur_row_ff + 6'd1;

      cur_row_in = cur_row_ff;
      long_q_in  = long_q_ff;
      long_r_in  = long_r_ff;
      short_q_in = short_q_ff;
      short_r_in = short_r_ff;
      if (cmd.setup) begin
         cur_row_in = vy_ff[0];
         long_q_in  = '0;
         long_r_in  = '0;
         short_q_in = '0;
         short_r_in = '0;
      end else if (cmd.emit_span) begin
         cur_row_in = next_row;
         long_q_in  = long_q_ff + a02 + 8'(long_ge);
         long_r_in  = long_ge ? 6'(long_sum - {1'b0, dy02}) : long_sum[5:0];
         if (next_row == vy_ff[1] && vy_ff[1] != vy_ff[2]) begin
            // lower half starts: second short edge from zero
            short_q_in = '0;
            short_r_in = '0;
         end else begin
            short_q_in = short_q_ff + s_a + 8'(short_ge);
            short_r_in = short_ge ? 6'(short_sum - {1'b0, s_d}) : short_sum[5:0];
         end
      end
   end

   // response register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit_flat) begin
         rsp_in.span_row   = vy_ff[0];
         rsp_in.span_left  = flat_lo;
         rsp_in.span_right = flat_hi;
         rsp_in.span_color = color_ff;
         rsp_in.last_span  = 1'b1;
      end else if (cmd.emit_span) begin
         rsp_in.span_row   = cur_row_ff;
         rsp_in.span_left  = (long_col < short_col) ? long_col : short_col;
         rsp_in.span_right = (long_col < short_col) ? short_col : long_col;
         rsp_in.span_color = color_ff;
         rsp_in.last_span  = status.row_last;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      color_ff   <= color_in;
      cur_row_ff <= cur_row_in;
      long_q_ff  <= long_q_in;
      long_r_ff  <= long_r_in;
      short_q_ff <= short_q_in;
      short_r_ff <= short_r_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit_flat | cmd.emit_span;
      end
   end

   // status toward the controller
   always_comb begin
      status.flat       = vy_ff[0] == vy_ff[2];
      status.off_screen = vy_ff[0] > LastRow;
      status.row_last   = (cur_row_ff == vy_ff[2]) || (cur_row_ff == LastRow);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

FILE: sv/tsg_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module tsg_controller
   import tsg_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_FLAT  = 5'b01000,
      ST_SPAN  = 5'b10000
   } state_type;

   localparam logic [2:0] DivLast = 3'(DivSteps - 1);

   state_type  state_ff, state_in;
   logic [2:0] div_cnt_ff, div_cnt_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup  = 1'b1;
            div_cnt_in = '0;
            if (status.off_screen) begin
               state_in = ST_IDLE;
            end else if (status.flat) begin
               state_in = ST_FLAT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 3'd1;
            if (div_cnt_ff == DivLast) begin
               state_in = ST_SPAN;
            end
         end
         ST_FLAT: begin
            cmd.emit_flat = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SPAN: begin
            cmd.emit_span = 1'b1;
            if (status.row_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

`default_nettype wire

FILE: sv/triangle_scanline_span_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Triangle scanline span generator.
// Request: drive req_item with three vertices and a color and raise start;
// the triangle transfers on a clock edge where start is high and busy is low.
// Busy stays high until the final span of the triangle has been issued.
// Response: one span per row, top row first, each on rsp_item for exactly one
// cycle with rsp_strobe high; last_span marks the final span of a triangle.
// A flat triangle gives one span; rows at or past ROWS are dropped, and a
// triangle whose top row is at or past ROWS gives no span at all.
// Timing: vertices are sorted as they transfer, then a setup state starts the
// three slope dividers (one quotient bit per cycle), then spans follow at one
// per cycle from a registered output; a flat triangle skips the dividers.
// The receiver cannot stall; spans are always taken as issued.
// Reset returns the controller to idle and drops any triangle in progress.
module triangle_scanline_span_generator_core
   import tsg_pkg::*;
#(
   parameter int unsigned ROWS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   tsg_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tsg_datapath #(
      .ROWS (ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tsg_pkg::*;

   localparam int unsigned ROW_LIMIT    = 64;
   localparam int unsigned RANDOM_ITEMS = 148;
   localparam int unsigned TAIL_CYCLES  = 16;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned NUM_DIRECTED = 22;

   // one row of the directed stimulus table
   typedef struct {
      req_type shape;
      bit      has_span;
      rsp_type known_span;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   rsp_type      expected_spans [$];
   stim_row_type directed_rows [NUM_DIRECTED];
   int unsigned  mismatch_count = 0;
   int unsigned  span_count = 0;
   int unsigned  cycle_count = 0;

   triangle_scanline_span_generator_core #(
      .ROWS(ROW_LIMIT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d spans still expected", cycle_count,
                  expected_spans.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] span %0d: %s", $realtime, span_count, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   function automatic req_type make_triangle(input int ax, input int ay,
                                             input int bx, input int by_row,
                                             input int cx, input int cy,
                                             input logic [15:0] fill_color);
      req_type t;
      t.ax         = 8'(ax);
      t.ay         = 6'(ay);
      t.bx         = 8'(bx);
      t.by_row     = 6'(by_row);
      t.cx         = 8'(cx);
      t.cy         = 6'(cy);
      t.fill_color = fill_color;
      return t;
   endfunction

   // the single, final span of a flat triangle
   function automatic rsp_type make_span(input int row, input int left,
                                         input int right, input logic [15:0] color);
      rsp_type s;
      s.span_row   = 6'(row);
      s.span_left  = 8'(left);
      s.span_right = 8'(right);
      s.span_color = color;
      s.last_span  = 1'b1;
      return s;
   endfunction

   function automatic rsp_type order_span(input int row, input int p, input int q,
                                          input logic [15:0] color);
      rsp_type s;
      s.span_row   = 6'(row);
      s.span_left  = 8'((p < q) ? p : q);
      s.span_right = 8'((p < q) ? q : p);
      s.span_color = color;
      s.last_span  = 1'b0;
      return s;
   endfunction

   // sort by row, walk both halves, queue the spans of one triangle
   task automatic predict_spans(input req_type shape);
      int      xs [3];
      int      ys [3];
      int      i, k, tmp, y, last_upper, sl, ss, p, q, lo, hi;
      int      dx01, dy01, dx02, dy02, dx12, dy12;
      rsp_type spans [$];
      xs[0] = int'(shape.ax);
      ys[0] = int'(shape.ay);
      xs[1] = int'(shape.bx);
      ys[1] = int'(shape.by_row);
      xs[2] = int'(shape.cx);
      ys[2] = int'(shape.cy);
      // three compare-swaps: pairs 0/1, 1/2, 0/1
      for (k = 0; k < 3; k++) begin
         i = (k == 1) ? 1 : 0;
         if (ys[i] > ys[i + 1]) begin
            tmp = ys[i]; ys[i] = ys[i + 1]; ys[i + 1] = tmp;
            tmp = xs[i]; xs[i] = xs[i + 1]; xs[i + 1] = tmp;
         end
      end
      if (ys[0] == ys[2]) begin
         // flat triangle: one span over the full column range
         lo = xs[0];
         hi = xs[0];
         for (k = 1; k < 3; k++) begin
            if (xs[k] < lo) lo = xs[k];
            if (xs[k] > hi) hi = xs[k];
         end
         if (ys[0] < ROW_LIMIT)
            spans.push_back(order_span(ys[0], lo, hi, shape.fill_color));
      end else begin
         dx01 = xs[1] - xs[0]; dy01 = ys[1] - ys[0];
         dx02 = xs[2] - xs[0]; dy02 = ys[2] - ys[0];
         dx12 = xs[2] - xs[1]; dy12 = ys[2] - ys[1];
         last_upper = (ys[1] == ys[2]) ? ys[1] : ys[1] - 1;
         // upper half: long edge against first short edge
         sl = 0;
         ss = 0;
         y  = ys[0];
         while (y <= last_upper) begin
            p = xs[0] + sl / dy02;
            q = (dy01 != 0) ? xs[0] + ss / dy01 : xs[0];
            if (y < ROW_LIMIT && spans.size() < 64)
               spans.push_back(order_span(y, p, q, shape.fill_color));
            sl += dx02;
            ss += dx01;
            y++;
         end
         // lower half: second short edge against long edge
         ss = dx12 * (y - ys[1]);
         sl = dx02 * (y - ys[0]);
         while (y <= ys[2]) begin
            p = (dy12 != 0) ? xs[1] + ss / dy12 : xs[1];
            q = xs[0] + sl / dy02;
            if (y < ROW_LIMIT && spans.size() < 64)
               spans.push_back(order_span(y, p, q, shape.fill_color));
            ss += dx12;
            sl += dx02;
            y++;
         end
      end
      if (spans.size() > 0)
         spans[spans.size() - 1].last_span = 1'b1;
      foreach (spans[n])
         expected_spans.push_back(spans[n]);
   endtask

   // random triangle, mostly shaped toward short, flat or edge cases
   function automatic req_type shaped_triangle();
      req_type     t;
      int unsigned base;
      t = make_triangle($urandom_range(0, 255), $urandom_range(0, 63),
                        $urandom_range(0, 255), $urandom_range(0, 63),
                        $urandom_range(0, 255), $urandom_range(0, 63), 16'($urandom));
      base = $urandom_range(0, 56);
      case ($urandom_range(0, 9))
         4, 5: begin
            // short triangle near a random row
            t.ay     = 6'(base + $urandom_range(0, 7));
            t.by_row = 6'(base + $urandom_range(0, 7));
            t.cy     = 6'(base + $urandom_range(0, 7));
         end
         6: begin
            t.by_row = t.ay;
            t.cy     = t.ay;
         end
         7: t.by_row = t.ay;
         8: t.cy = t.by_row;
         9: begin
            // columns and the first vertex's row pushed to their limits
            t.ax = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            t.bx = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            t.cx = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            t.ay = ($urandom_range(0, 1) == 1) ? 6'h3F : 6'h00;
         end
         default: ;
      endcase
      return t;
   endfunction

   // present one triangle after an idle gap, return on its transfer
   task automatic send_triangle(input req_type shape, input int unsigned gap);
      if (gap != 0) begin
         start    <= 1'b0;
         req_item <= shaped_triangle();
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= shape;
      do @(posedge clock); while (busy);
   endtask

   // hold off until every expected span has come out
   task automatic wait_for_spans();
      start <= 1'b0;
      do @(posedge clock); while (expected_spans.size() != 0);
   endtask

   // span checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_spans.size() == 0) begin
            report_mismatch($sformatf("unexpected span transfer, row %0d",
                                      rsp_item.span_row));
         end else begin
            want = expected_spans.pop_front();
            check_field("span_row", int'(rsp_item.span_row), int'(want.span_row));
            check_field("span_left", int'(rsp_item.span_left), int'(want.span_left));
            check_field("span_right", int'(rsp_item.span_right), int'(want.span_right));
            check_field("span_color", int'(rsp_item.span_color), int'(want.span_color));
            check_field("last_span", int'(rsp_item.last_span), int'(want.last_span));
         end
         span_count++;
      end
   end

   initial begin
      req_type shape;
      bit      no_idle;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      no_idle  = 1'b0;

      // flat cases carry their span; the rest go through the predictor
      directed_rows = '{
         '{make_triangle(0, 0, 255, 0, 128, 0, 16'h0000), 1'b1,
           make_span(0, 0, 255, 16'h0000)},
         '{make_triangle(200, 63, 10, 63, 77, 63, 16'hFFFF), 1'b1,
           make_span(63, 10, 200, 16'hFFFF)},
         '{make_triangle(0, 0, 0, 0, 0, 0, 16'h1234), 1'b1,
           make_span(0, 0, 0, 16'h1234)},
         '{make_triangle(255, 63, 255, 63, 255, 63, 16'hA5A5), 1'b1,
           make_span(63, 255, 255, 16'hA5A5)},
         '{make_triangle(40, 31, 40, 31, 90, 31, 16'h5A5A), 1'b1,
           make_span(31, 40, 90, 16'h5A5A)},
         '{make_triangle(0, 0, 255, 63, 0, 63, 16'hFFFF), 1'b0, '0},
         '{make_triangle(128, 0, 0, 63, 255, 63, 16'h0001), 1'b0, '0},
         '{make_triangle(0, 0, 255, 0, 128, 63, 16'hF800), 1'b0, '0},
         '{make_triangle(255, 0, 0, 32, 255, 63, 16'h07E0), 1'b0, '0},
         '{make_triangle(0, 0, 255, 32, 0, 63, 16'h001F), 1'b0, '0},
         '{make_triangle(10, 5, 200, 20, 60, 50, 16'hC0DE), 1'b0, '0},
         '{make_triangle(10, 5, 60, 50, 200, 20, 16'hC0DE), 1'b0, '0},
         '{make_triangle(200, 20, 10, 5, 60, 50, 16'hC0DE), 1'b0, '0},
         '{make_triangle(200, 20, 60, 50, 10, 5, 16'hC0DE), 1'b0, '0},
         '{make_triangle(60, 50, 10, 5, 200, 20, 16'hC0DE), 1'b0, '0},
         '{make_triangle(60, 50, 200, 20, 10, 5, 16'hC0DE), 1'b0, '0},
         '{make_triangle(5, 10, 9, 11, 0, 10, 16'h8000), 1'b0, '0},
         '{make_triangle(100, 20, 30, 40, 170, 40, 16'h7FFF), 1'b0, '0},
         '{make_triangle(50, 2, 60, 2, 55, 3, 16'hAAAA), 1'b0, '0},
         '{make_triangle(255, 0, 0, 63, 128, 1, 16'h5555), 1'b0, '0},
         '{make_triangle(3, 40, 250, 7, 120, 40, 16'h0F0F), 1'b0, '0},
         '{make_triangle(1, 62, 254, 1, 127, 63, 16'hF0F0), 1'b0, '0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         send_triangle(directed_rows[i].shape, $urandom_range(0, 3));
         if (directed_rows[i].has_span)
            expected_spans.push_back(directed_rows[i].known_span);
         else
            predict_spans(directed_rows[i].shape);
      end
      wait_for_spans();

      // random triangles, idle gaps switched off in some stretches
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 12 == 0)
            no_idle = ($urandom_range(0, 2) == 0);
         if (n == RANDOM_ITEMS / 2)
            wait_for_spans();
         shape = shaped_triangle();
         send_triangle(shape, no_idle ? 0 : $urandom_range(0, 3));
         predict_spans(shape);
      end
      start <= 1'b0;

      while (expected_spans.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
